/* src/tccu_pkg.sv */
// Shared types and constants for the text console cursor engine.
package tccu_pkg;

  // Field widths of the request and result payloads
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // Character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7f;

  // Configuration register indexes and reset values
  localparam int                 CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG  = 1'b1;
  localparam logic [COLOR_W-1:0] BG_RESET  = 4'd0;
  localparam logic [COLOR_W-1:0] FG_RESET  = 4'd15;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the accepted request
    logic exec;      // run the single-cycle part of the operation
    logic copy;      // one step of the scroll copy
    logic fill;      // write one blank cell
    logic out_load;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll;     // put character runs past the last row
    logic            copy_last;  // every scroll read issued
    logic            fill_last;  // last cell of the fill
  } status_t;

endpackage

/* src/tccu_if.sv */
// Request and result channel interfaces of the text console cursor engine.
interface tccu_in_if;
  logic                           valid;
  logic                           ready;
  logic [tccu_pkg::OP_W-1:0]      op;
  logic [tccu_pkg::CHAR_W-1:0]    char_code;
  logic [tccu_pkg::COL_W-1:0]     target_col;
  logic [tccu_pkg::ROW_W-1:0]     target_row;

  modport source (output valid, op, char_code, target_col, target_row, input ready);
  modport sink   (input valid, op, char_code, target_col, target_row, output ready);
endinterface

interface tccu_out_if;
  logic                           valid;
  logic                           ready;
  logic [tccu_pkg::POS_W-1:0]     cursor_position;
  logic [tccu_pkg::CELL_W-1:0]    cell_value;

  modport source (output valid, cursor_position, cell_value, input ready);
  modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

/* src/tccu_ctrl.sv */
// Controller state machine of the text console cursor engine.
module tccu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tccu_pkg::status_t   status,
  output tccu_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode state into commands and pick the next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op == tccu_pkg::OP_CLEAR) begin
          state_nxt = S_FILL;
        end else if (status.op == tccu_pkg::OP_PUT && status.scroll) begin
          state_nxt = S_COPY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (status.copy_last) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/tccu_datapath.sv */
// Datapath of the text console cursor engine: cursor, screen store, result register.
module tccu_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tccu_pkg::cmd_t                   cmd,
  output tccu_pkg::status_t                status,
  input  logic [tccu_pkg::OP_W-1:0]        in_op,
  input  logic [tccu_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tccu_pkg::COL_W-1:0]       in_target_col,
  input  logic [tccu_pkg::ROW_W-1:0]       in_target_row,
  input  logic                             cfg_we,
  input  logic [tccu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccu_pkg::COLOR_W-1:0]     cfg_wdata,
  output logic [tccu_pkg::POS_W-1:0]       out_cursor_position,
  output logic [tccu_pkg::CELL_W-1:0]      out_cell_value
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int STOPS  = COLUMNS / TAB_WIDTH + 1;
  localparam int CW1    = tccu_pkg::COL_W + 1;
  localparam int RW1    = tccu_pkg::ROW_W + 1;
  localparam int CW     = tccu_pkg::CELL_W;

  // Request, cursor and configuration registers
  logic [tccu_pkg::OP_W-1:0]    op_r;
  logic [tccu_pkg::CHAR_W-1:0]  code_r;
  logic [tccu_pkg::COL_W-1:0]   tcol_r;
  logic [tccu_pkg::ROW_W-1:0]   trow_r;
  logic [tccu_pkg::COL_W-1:0]   cur_col_r;
  logic [tccu_pkg::COL_W-1:0]   cur_col_nxt;
  logic [tccu_pkg::ROW_W-1:0]   cur_row_r;
  logic [tccu_pkg::ROW_W-1:0]   cur_row_nxt;
  logic [tccu_pkg::COLOR_W-1:0] bg_r;
  logic [tccu_pkg::COLOR_W-1:0] fg_r;

  // Walk counter and copy pipeline
  logic [AW-1:0]  ctr_r;
  logic           cp_pend_r;
  logic [AW-1:0]  cp_dst_r;

  // Screen store
  logic [CW-1:0]  mem [CELLS];
  logic [CW-1:0]  rd_data_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [CW-1:0]  mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  // Result register
  logic [tccu_pkg::POS_W-1:0] pos_r;
  logic [CW-1:0]              cell_r;

  // Combinational helpers
  logic [tccu_pkg::COL_W-1:0] tcol_c;
  logic [tccu_pkg::ROW_W-1:0] trow_c;
  logic [AW-1:0]              cur_addr;
  logic [AW-1:0]              tgt_addr;
  logic [CW-1:0]              blank;
  logic [tccu_pkg::CHAR_W-1:0] attr;
  logic                       printable;
  logic [CW1-1:0]             tab_stop;
  logic [CW1-1:0]             col8;
  logic [RW1-1:0]             row6;
  logic                       scroll;

  // Clamp target coordinates to the screen
  assign tcol_c = ({1'b0, tcol_r} >= CW1'(COLUMNS)) ? tccu_pkg::COL_W'(COLUMNS - 1) : tcol_r;
  assign trow_c = ({1'b0, trow_r} >= RW1'(ROWS)) ? tccu_pkg::ROW_W'(ROWS - 1) : trow_r;

  assign cur_addr = AW'(AW'(cur_row_r) * AW'(COLUMNS) + AW'(cur_col_r));
  assign tgt_addr = AW'(AW'(trow_c) * AW'(COLUMNS) + AW'(tcol_c));
  assign attr     = {bg_r, fg_r};
  assign blank    = {attr, tccu_pkg::CH_SPACE};

  assign printable = (code_r >= tccu_pkg::CH_SPACE) && (code_r <= tccu_pkg::CH_PRINT_HI);

  // Find the next tab stop past the cursor column
  always_comb begin
    tab_stop = {1'b0, cur_col_r};
    for (int k = STOPS; k >= 1; k--) begin
      if ({1'b0, cur_col_r} < CW1'(k * TAB_WIDTH)) begin
        tab_stop = CW1'(k * TAB_WIDTH);
      end
    end
  end

  // Advance the cursor for a put character request
  always_comb begin
    col8 = {1'b0, cur_col_r};
    row6 = {1'b0, cur_row_r};
    if (printable) begin
      col8 = col8 + CW1'(1);
    end else if (code_r == tccu_pkg::CH_BS) begin
      if (col8 != '0) begin
        col8 = col8 - CW1'(1);
      end
    end else if (code_r == tccu_pkg::CH_TAB) begin
      col8 = tab_stop;
    end else if (code_r == tccu_pkg::CH_LF) begin
      col8 = '0;
      row6 = row6 + RW1'(1);
    end else if (code_r == tccu_pkg::CH_CR) begin
      col8 = '0;
    end
    // wrap at the last column
    if (col8 >= CW1'(COLUMNS)) begin
      col8 = '0;
      row6 = row6 + RW1'(1);
    end
    scroll = (row6 >= RW1'(ROWS));
    if (scroll) begin
      row6 = RW1'(ROWS - 1);
    end
  end

  // Pick the next cursor
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.exec) begin
      case (op_r)
        tccu_pkg::OP_PUT: begin
          cur_col_nxt = col8[tccu_pkg::COL_W-1:0];
          cur_row_nxt = row6[tccu_pkg::ROW_W-1:0];
        end
        tccu_pkg::OP_CLEAR: begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
        tccu_pkg::OP_MOVE: begin
          cur_col_nxt = tcol_c;
          cur_row_nxt = trow_c;
        end
        default: begin
          cur_col_nxt = cur_col_r;
          cur_row_nxt = cur_row_r;
        end
      endcase
    end
  end

  // Screen store write and read port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ctr_r;
    mem_wdata = blank;
    if (cp_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = cp_dst_r;
      mem_wdata = rd_data_r;
    end else if (cmd.fill) begin
      mem_we    = 1'b1;
      mem_waddr = ctr_r;
      mem_wdata = blank;
    end else if (cmd.exec && op_r == tccu_pkg::OP_PUT && printable) begin
      mem_we    = 1'b1;
      mem_waddr = cur_addr;
      mem_wdata = {attr, code_r};
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = tgt_addr;
    if (cmd.copy) begin
      mem_re    = (ctr_r != AW'(COPY_N));
      mem_raddr = AW'(ctr_r + AW'(COLUMNS));
    end else if (cmd.exec && op_r == tccu_pkg::OP_READ) begin
      mem_re    = 1'b1;
      mem_raddr = tgt_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      code_r <= in_char_code;
      tcol_r <= in_target_col;
      trow_r <= in_target_row;
    end
  end

  // Cursor, configuration and copy pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      bg_r      <= tccu_pkg::BG_RESET;
      fg_r      <= tccu_pkg::FG_RESET;
      cp_pend_r <= 1'b0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      cp_pend_r <= cmd.copy && (ctr_r != AW'(COPY_N));
      if (cfg_we && cfg_index == tccu_pkg::CFG_BG) begin
        bg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == tccu_pkg::CFG_FG) begin
        fg_r <= cfg_wdata;
      end
    end
  end

  // Walk counter: start at zero, advance on each copy read and fill write
  always_ff @(posedge clk) begin
    cp_dst_r <= ctr_r;
    if (cmd.exec) begin
      ctr_r <= '0;
    end else if (cmd.copy && ctr_r != AW'(COPY_N)) begin
      ctr_r <= ctr_r + AW'(1);
    end else if (cmd.fill) begin
      ctr_r <= ctr_r + AW'(1);
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_r  <= tccu_pkg::POS_W'(AW'(cur_row_r) * AW'(COLUMNS) + AW'(cur_col_r));
      cell_r <= (op_r == tccu_pkg::OP_READ) ? rd_data_r : '0;
    end
  end

  assign out_cursor_position = pos_r;
  assign out_cell_value      = cell_r;

  assign status.op        = op_r;
  assign status.scroll    = scroll;
  assign status.copy_last = (ctr_r == AW'(COPY_N));
  assign status.fill_last = (ctr_r == AW'(CELLS - 1));

endmodule

/* src/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine.
// Text console with a COLUMNS x ROWS store of 16-bit cells and a cursor. One request
// is taken at a time; put character without a scroll, move cursor and read cell pass
// through the execute and done states, and the done state loads the result register
// once that register is free. A put character that runs past the last row scrolls the
// screen through the screen store, with one read port and one write port, one cell per
// cycle: each row below the top is copied up one row, then the last row is blanked.
// Clear screen blanks every cell. The next request is taken as soon as the result is
// in the output register, even while that result waits. The screen store holds no
// reset value: a cell reads back only after it has been written. The user must write
// colors on the cfg port only while idle; the block itself does not enforce it.
module text_console_cursor_engine_unit #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tccu_in_if.sink                         in_req,
  tccu_out_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  logic [tccu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccu_pkg::COLOR_W-1:0]    cfg_wdata
);

  tccu_pkg::cmd_t    cmd;
  tccu_pkg::status_t status;

  // Sequence each request
  tccu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Cursor, screen store and result
  tccu_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_op               (in_req.op),
    .in_char_code        (in_req.char_code),
    .in_target_col       (in_req.target_col),
    .in_target_row       (in_req.target_row),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_cursor_position (out_rsp.cursor_position),
    .out_cell_value      (out_rsp.cell_value)
  );

endmodule

/* src/tccu_checker.sv */
// Port-level checker for the text console cursor engine, with its bind.
module tccu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tccu_pkg::POS_W-1:0]   cursor_position,
  input logic [tccu_pkg::CELL_W-1:0]  cell_value
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count requests whose result has not been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cursor_position) && $stable(cell_value))
    else $error("result payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r < 2'd2)
    else $error("request taken with two requests outstanding");

endmodule

bind text_console_cursor_engine_unit tccu_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .cursor_position (out_rsp.cursor_position),
  .cell_value      (out_rsp.cell_value)
);
